FILE: hdl/sdtp_pkg.sv
// Package for the slash date text parser: scan phase, status codes, parser
// state and result types, and the per-character helper functions.
// No dependencies.
`default_nettype none

package sdtp_pkg;

  localparam int unsigned CH_W   = 8;
  localparam int unsigned MAG_W  = 31;
  localparam int unsigned YEAR_W = 32;
  localparam int unsigned FLD_W  = 3;
  localparam int unsigned STAT_W = 3;

  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

  // Characters of interest
  localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0D;

  // Range limits
  localparam logic [MAG_W-1:0] MONTH_MAX = 31'd12;
  localparam logic [MAG_W-1:0] DAY_MAX   = 31'd31;
  localparam logic [MAG_W-1:0] HOUR_MAX  = 31'd23;
  localparam logic [MAG_W-1:0] MIN_MAX   = 31'd59;

  // Field slots
  localparam logic [FLD_W-1:0] FLD_YEAR   = 3'd0;
  localparam logic [FLD_W-1:0] FLD_MONTH  = 3'd1;
  localparam logic [FLD_W-1:0] FLD_DAY    = 3'd2;
  localparam logic [FLD_W-1:0] FLD_HOUR   = 3'd3;
  localparam logic [FLD_W-1:0] FLD_MINUTE = 3'd4;
  localparam logic [FLD_W-1:0] FLD_SECOND = 3'd5;
  localparam logic [FLD_W-1:0] FLD_LAST   = 3'd7;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
  localparam logic [STAT_W-1:0] ST_MALFORMED  = 3'd1;
  localparam logic [STAT_W-1:0] ST_BAD_MONTH  = 3'd2;
  localparam logic [STAT_W-1:0] ST_BAD_DAY    = 3'd3;
  localparam logic [STAT_W-1:0] ST_BAD_HOUR   = 3'd4;
  localparam logic [STAT_W-1:0] ST_BAD_MINUTE = 3'd5;
  localparam logic [STAT_W-1:0] ST_BAD_SECOND = 3'd6;
  localparam logic [STAT_W-1:0] ST_TOO_MANY   = 3'd7;

  typedef enum logic [1:0] {
    PH_WAIT  = 2'd0,
    PH_TOKEN = 2'd1,
    PH_AFTER = 2'd2
  } phase_t;

  typedef struct packed {
    logic signed [YEAR_W-1:0] year;
    logic [3:0]               month;
    logic [4:0]               day;
    logic [4:0]               hour;
    logic [5:0]               minute;
    logic [5:0]               second;
    logic [STAT_W-1:0]        status;
  } date_t;

  typedef struct packed {
    phase_t            phase;
    logic [FLD_W-1:0]  field_number;
    logic [MAG_W-1:0]  token_value;
    logic              token_negative;
    logic              token_position;
    logic              token_stopped;
    date_t             date;
  } parse_t;

  localparam parse_t PARSE_RESET = '{
    phase:          PH_WAIT,
    field_number:   '0,
    token_value:    '0,
    token_negative: 1'b0,
    token_position: 1'b0,
    token_stopped:  1'b0,
    date:           '0
  };

  function automatic logic is_space(input logic [CH_W-1:0] c);
    is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [CH_W-1:0] c);
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // One character into the running token (atoi style, saturating magnitude)
  function automatic parse_t take_char(input parse_t s, input logic [CH_W-1:0] c);
    parse_t           r;
    logic [MAG_W+3:0] m;
    logic [CH_W-1:0]  d;
    r = s;
    d = c - CH_ZERO;
    m = {3'b000, s.token_value, 1'b0} + {s.token_value, 3'b000}
        + {{(MAG_W-4){1'b0}}, d};
    if (!s.token_stopped) begin
      if (!s.token_position && ((c == CH_PLUS) || (c == CH_MINUS))) begin
        r.token_position = 1'b1;
        r.token_negative = (c == CH_MINUS);
      end else begin
        r.token_position = 1'b1;
        if (is_digit(c)) begin
          r.token_value = (m > {4'b0000, MAG_MAX}) ? MAG_MAX : m[MAG_W-1:0];
        end else begin
          r.token_stopped = 1'b1;
        end
      end
    end
    return r;
  endfunction

  function automatic logic in_range(input parse_t s, input logic [MAG_W-1:0] lo,
                                    input logic [MAG_W-1:0] hi);
    if (s.token_negative && (s.token_value != '0)) return 1'b0;
    return (s.token_value >= lo) && (s.token_value <= hi);
  endfunction

  // Close the current token into its field slot
  function automatic parse_t finish_token(input parse_t s);
    parse_t r;
    r = s;
    if (s.field_number != FLD_LAST) r.field_number = s.field_number + 1'b1;
    unique case (s.field_number)
      FLD_YEAR: begin
        r.date.year = s.token_negative ? -$signed({1'b0, s.token_value})
                                       : $signed({1'b0, s.token_value});
      end
      FLD_MONTH: begin
        if (in_range(s, 31'd1, MONTH_MAX)) r.date.month = s.token_value[3:0];
        else r.date.status = ST_BAD_MONTH;
      end
      FLD_DAY: begin
        if (in_range(s, 31'd1, DAY_MAX)) r.date.day = s.token_value[4:0];
        else r.date.status = ST_BAD_DAY;
      end
      FLD_HOUR: begin
        if (in_range(s, 31'd0, HOUR_MAX)) r.date.hour = s.token_value[4:0];
        else r.date.status = ST_BAD_HOUR;
      end
      FLD_MINUTE: begin
        if (in_range(s, 31'd0, MIN_MAX)) r.date.minute = s.token_value[5:0];
        else r.date.status = ST_BAD_MINUTE;
      end
      FLD_SECOND: begin
        if (in_range(s, 31'd0, MIN_MAX)) r.date.second = s.token_value[5:0];
        else r.date.status = ST_BAD_SECOND;
      end
      default: begin
        r.date.status = ST_TOO_MANY;
      end
    endcase
    return r;
  endfunction

  // Start a fresh token with its first character
  function automatic parse_t start_token(input parse_t s, input logic [CH_W-1:0] c);
    parse_t r;
    r = s;
    r.token_value    = '0;
    r.token_negative = 1'b0;
    r.token_position = 1'b0;
    r.token_stopped  = 1'b0;
    return take_char(r, c);
  endfunction

endpackage

`default_nettype wire

FILE: hdl/sdtp_if.sv
// Channel interfaces of the slash date text parser: character input and
// date result output. Depends on sdtp_pkg.
`default_nettype none

interface sdtp_char_if
  import sdtp_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  logic            end_of_text;

  modport source (output valid, output ch, output end_of_text, input ready);
  modport sink   (input valid, input ch, input end_of_text, output ready);
endinterface

interface sdtp_date_if
  import sdtp_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [YEAR_W-1:0] year;
  logic [3:0]               month;
  logic [4:0]               day;
  logic [4:0]               hour;
  logic [5:0]               minute;
  logic [5:0]               second;
  logic [STAT_W-1:0]        status;

  modport source (output valid, output year, output month, output day, output hour,
                  output minute, output second, output status, input ready);
  modport sink   (input valid, input year, input month, input day, input hour,
                  input minute, input second, input status, output ready);
endinterface

`default_nettype wire

FILE: hdl/slash_date_text_parser_unit.sv
// Top level of the slash date text parser: per-character scanner state,
// result register and skid register. Depends on sdtp_pkg and sdtp_if.
//
//   channel   | dir | payload                                  | per
//   ----------+-----+------------------------------------------+------------------
//   char_in   | in  | ch, end_of_text                          | character or end
//   date_out  | out | year, month, day, hour, minute, second,  | end item
//             |     | status                                   |
//
// One character per cycle while char_in is ready: the scanner state updates
// in the accepting cycle through one multiply-by-ten add. An end item's result
// is registered into the output slot, or the skid slot if the output stalls.
// Two result slots keep char_in ready while one result stalls; char_in drops
// ready only with both full. Synchronous reset clears the scanner and both slots.
`default_nettype none

module slash_date_text_parser_unit
  import sdtp_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  sdtp_char_if.sink   char_in,
  sdtp_date_if.source date_out
);

  parse_t st;
  parse_t st_next;
  date_t  res;
  date_t  out_data;
  date_t  skid_data;
  logic   out_valid;
  logic   skid_valid;
  logic   accept;
  logic   push;
  logic   out_free;

  assign accept   = char_in.valid && char_in.ready;
  assign push     = accept && char_in.end_of_text;
  assign out_free = !out_valid || date_out.ready;

  // Scanner next state and result of an end item
  always_comb begin
    parse_t fin;
    st_next = st;
    fin     = st;
    if ((st.date.status == ST_OK) && (st.phase == PH_TOKEN)) fin = finish_token(st);
    res = fin.date;
    if (char_in.end_of_text) begin
      st_next = PARSE_RESET;
    end else if (st.date.status == ST_OK) begin
      unique case (st.phase)
        PH_WAIT: begin
          if (!is_space(char_in.ch)) begin
            st_next       = start_token(st, char_in.ch);
            st_next.phase = PH_TOKEN;
          end
        end
        PH_TOKEN: begin
          if (is_space(char_in.ch)) begin
            st_next       = finish_token(st);
            st_next.phase = PH_AFTER;
          end else if (char_in.ch == CH_SLASH) begin
            st_next       = finish_token(st);
            st_next.phase = PH_WAIT;
          end else begin
            st_next = take_char(st, char_in.ch);
          end
        end
        default: begin
          if (is_space(char_in.ch)) begin
            st_next = st;
          end else if (char_in.ch == CH_SLASH) begin
            st_next.phase = PH_WAIT;
          end else begin
            st_next.date.status = ST_MALFORMED;
          end
        end
      endcase
    end
  end

  // Scanner state register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= PARSE_RESET;
    end else if (accept) begin
      st <= st_next;
    end
  end

  // Output register with skid slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) out_data <= skid_data;
      else if (push) out_data <= res;
    end else if (push) begin
      skid_data <= res;
    end
  end

  // Handshake and payload outputs
  always_comb begin
    char_in.ready   = !skid_valid;
    date_out.valid  = out_valid;
    date_out.year   = out_data.year;
    date_out.month  = out_data.month;
    date_out.day    = out_data.day;
    date_out.hour   = out_data.hour;
    date_out.minute = out_data.minute;
    date_out.second = out_data.second;
    date_out.status = out_data.status;
  end

endmodule

`default_nettype wire
